@@ hw/rtl/drq_pkg.sv @@
package drq_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned NumRequestersDefault = 8;
  localparam int unsigned KeyBitsDefault = 32;
  localparam int unsigned TimeBitsDefault = 48;
  localparam int unsigned CfgBits = 6;
  localparam logic [CfgBits-1:0] PruneMinReset = CfgBits'(20);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_POP   = 2'd1,
    OP_PRUNE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_INSERT,
    S_POP,
    S_PRUNE,
    S_CLEAR
  } state_e;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_FIND,
    MODE_INSERT,
    MODE_REMOVE
  } mode_e;

  typedef enum logic [1:0] {
    PRED_ALL,
    PRED_POP,
    PRED_CLEAR
  } pred_e;

  typedef struct packed {
    mode_e mode;
    pred_e pred;
  } ctl_t;

endpackage

@@ hw/rtl/drq_cell.sv @@
module drq_cell #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned REQ_BITS = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  drq_pkg::ctl_t           ctl_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [TIME_BITS-1:0]    time_i,
  input  logic [REQ_BITS-1:0]     new_req_i,
  input  logic [REQ_BITS-1:0]     clr_req_i,
  input  logic [(1<<REQ_BITS)-1:0] excl_i,
  input  logic                    prev_valid_i,
  input  logic [KEY_BITS-1:0]     prev_key_i,
  input  logic [TIME_BITS-1:0]    prev_dl_i,
  input  logic [REQ_BITS-1:0]     prev_req_i,
  input  logic                    prev_before_i,
  input  logic                    next_valid_i,
  input  logic [KEY_BITS-1:0]     next_key_i,
  input  logic [TIME_BITS-1:0]    next_dl_i,
  input  logic [REQ_BITS-1:0]     next_req_i,
  input  logic                    mc_i,
  input  logic                    rm_i,
  output logic                    valid_o,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [TIME_BITS-1:0]    dl_o,
  output logic [REQ_BITS-1:0]     req_o,
  output logic                    before_o,
  output logic                    mc_o,
  output logic                    rm_o,
  output logic                    first_o,
  output logic                    match_o,
  output logic                    stale_o
);
  import drq_pkg::*;

  logic                 valid_q, valid_d, match_q, match_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic [REQ_BITS-1:0]  req_q, req_d;
  logic                 sel;

  assign match_o  = valid_q && (key_q == key_i);
  assign stale_o  = valid_q && (dl_q < time_i);
  assign before_o = !valid_q || (time_i < dl_q) ||
                    ((time_i == dl_q) && ((new_req_i < req_q) ||
                     ((new_req_i == req_q) && (key_i < key_q))));
  assign mc_o = mc_i || match_q;

  always_comb begin
    case (ctl_i.pred)
      PRED_POP:   sel = valid_q && !excl_i[req_q];
      PRED_CLEAR: sel = valid_q && (req_q == clr_req_i);
      default:    sel = valid_q;
    endcase
  end

  assign rm_o    = rm_i || sel;
  assign first_o = sel && !rm_i;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    dl_d    = dl_q;
    req_d   = req_q;
    match_d = match_q;
    unique case (ctl_i.mode)
      MODE_FIND: match_d = match_o;
      MODE_INSERT: begin
        if (before_o && !prev_before_i) begin
          valid_d = 1'b1;
          key_d   = key_i;
          dl_d    = time_i;
          req_d   = new_req_i;
        end else if (prev_before_i && !mc_i) begin
          valid_d = prev_valid_i;
          key_d   = prev_key_i;
          dl_d    = prev_dl_i;
          req_d   = prev_req_i;
        end
      end
      MODE_REMOVE: begin
        if (rm_o) begin
          valid_d = next_valid_i;
          key_d   = next_key_i;
          dl_d    = next_dl_i;
          req_d   = next_req_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    dl_q  <= dl_d;
    req_q <= req_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign dl_o    = dl_q;
  assign req_o   = req_q;

endmodule

@@ hw/rtl/deadline_request_queue_unit.sv @@
// Deadline-ordered request queue built as a row of cells, one entry per cell,
// kept packed and sorted by deadline, requester and key. An add goes through
// acceptance, a key search and a shifted insert before its result, a pop
// through acceptance and the removal, and a prune or clear removes its entries
// one per cycle through the neighbor shift before it gives its result. The
// result sits in an output register, so the next word is accepted while the
// previous result still waits. The prune threshold may only be written while
// the queue is idle.
module deadline_request_queue_unit #(
  parameter int unsigned DEPTH = drq_pkg::DepthDefault,
  parameter int unsigned NUM_REQUESTERS = drq_pkg::NumRequestersDefault,
  parameter int unsigned KEY_BITS = drq_pkg::KeyBitsDefault,
  parameter int unsigned TIME_BITS = drq_pkg::TimeBitsDefault,
  localparam int unsigned REQ_BITS = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1,
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [drq_pkg::CfgBits-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [KEY_BITS-1:0]           req_key_i,
  input  logic [TIME_BITS-1:0]          time_value_i,
  input  logic [REQ_BITS-1:0]           requester_i,
  input  logic [NUM_REQUESTERS-1:0]     exclude_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic                          dropped_o,
  output logic [KEY_BITS-1:0]           out_key_o,
  output logic [TIME_BITS-1:0]          out_deadline_o,
  output logic [REQ_BITS-1:0]           out_requester_o,
  output logic [CNT_BITS-1:0]           occupancy_o
);
  import drq_pkg::*;

  localparam int unsigned ExW = 1 << REQ_BITS;

  state_e state_q, state_d;
  op_e    op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [TIME_BITS-1:0] tv_q;
  logic [REQ_BITS-1:0]  rq_q;
  logic [ExW-1:0]       ex_q;
  logic                 prune_en_q, any_q, lower_q;
  logic [REQ_BITS-1:0]  mreq_q;
  logic [CNT_BITS-1:0]  pending_q, pending_nxt;
  logic [CfgBits-1:0]   min_q;

  logic                 out_valid_q, found_q, dropped_q;
  logic [KEY_BITS-1:0]  okey_q;
  logic [TIME_BITS-1:0] odl_q;
  logic [REQ_BITS-1:0]  oreq_q;
  logic [CNT_BITS-1:0]  occ_q;

  ctl_t ctl;
  logic finish, inc, dec, out_free, accept, full, do_insert, rm_any, prune_cond;
  logic [REQ_BITS-1:0] new_req;

  logic [DEPTH-1:0] c_valid, c_before, c_mc, c_rm, c_first, c_match, c_stale;
  logic [KEY_BITS-1:0]  c_key [DEPTH];
  logic [TIME_BITS-1:0] c_dl  [DEPTH];
  logic [REQ_BITS-1:0]  c_req [DEPTH];

  logic                 m_any;
  logic [REQ_BITS-1:0]  m_req;
  logic [TIME_BITS-1:0] m_dl;
  logic [KEY_BITS-1:0]  f_key;
  logic [TIME_BITS-1:0] f_dl;
  logic [REQ_BITS-1:0]  f_req;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = !(pending_q < CNT_BITS'(DEPTH));
  assign new_req  = any_q ? mreq_q : rq_q;
  assign do_insert = any_q ? lower_q : !full;
  assign rm_any   = c_rm[DEPTH-1];
  assign prune_cond = prune_en_q && (pending_q >= CNT_BITS'(2)) && c_stale[1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 p_valid, p_before, n_valid, mc_in, rm_in;
    logic [KEY_BITS-1:0]  p_key, n_key;
    logic [TIME_BITS-1:0] p_dl, n_dl;
    logic [REQ_BITS-1:0]  p_req, n_req;

    if (g == 0) begin : g_first
      assign p_valid  = 1'b0;
      assign p_key    = '0;
      assign p_dl     = '0;
      assign p_req    = '0;
      assign p_before = 1'b0;
      assign mc_in    = 1'b0;
      assign rm_in    = 1'b0;
    end else begin : g_mid
      assign p_valid  = c_valid[g-1];
      assign p_key    = c_key[g-1];
      assign p_dl     = c_dl[g-1];
      assign p_req    = c_req[g-1];
      assign p_before = c_before[g-1];
      assign mc_in    = c_mc[g-1];
      assign rm_in    = c_rm[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_dl    = '0;
      assign n_req   = '0;
    end else begin : g_inner
      assign n_valid = c_valid[g+1];
      assign n_key   = c_key[g+1];
      assign n_dl    = c_dl[g+1];
      assign n_req   = c_req[g+1];
    end

    drq_cell #(
      .KEY_BITS (KEY_BITS),
      .TIME_BITS(TIME_BITS),
      .REQ_BITS (REQ_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key_q),
      .time_i       (tv_q),
      .new_req_i    (new_req),
      .clr_req_i    (rq_q),
      .excl_i       (ex_q),
      .prev_valid_i (p_valid),
      .prev_key_i   (p_key),
      .prev_dl_i    (p_dl),
      .prev_req_i   (p_req),
      .prev_before_i(p_before),
      .next_valid_i (n_valid),
      .next_key_i   (n_key),
      .next_dl_i    (n_dl),
      .next_req_i   (n_req),
      .mc_i         (mc_in),
      .rm_i         (rm_in),
      .valid_o      (c_valid[g]),
      .key_o        (c_key[g]),
      .dl_o         (c_dl[g]),
      .req_o        (c_req[g]),
      .before_o     (c_before[g]),
      .mc_o         (c_mc[g]),
      .rm_o         (c_rm[g]),
      .first_o      (c_first[g]),
      .match_o      (c_match[g]),
      .stale_o      (c_stale[g])
    );
  end

  always_comb begin
    m_any = 1'b0;
    m_req = '0;
    m_dl  = '0;
    f_key = '0;
    f_dl  = '0;
    f_req = '0;
    for (int i = 0; i < DEPTH; i++) begin
      m_any = m_any | c_match[i];
      m_req = m_req | (c_req[i] & {REQ_BITS{c_match[i]}});
      m_dl  = m_dl  | (c_dl[i]  & {TIME_BITS{c_match[i]}});
      f_key = f_key | (c_key[i] & {KEY_BITS{c_first[i]}});
      f_dl  = f_dl  | (c_dl[i]  & {TIME_BITS{c_first[i]}});
      f_req = f_req | (c_req[i] & {REQ_BITS{c_first[i]}});
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(op_i))
            OP_ADD:   state_d = S_FIND;
            OP_POP:   state_d = S_POP;
            OP_PRUNE: state_d = S_PRUNE;
            OP_CLEAR: state_d = S_CLEAR;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_FIND:   state_d = S_INSERT;
      S_INSERT: if (out_free) state_d = S_IDLE;
      S_POP:    if (out_free) state_d = S_IDLE;
      S_PRUNE:  if (!prune_cond && out_free) state_d = S_IDLE;
      S_CLEAR:  if (!rm_any && out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.mode = MODE_HOLD;
    ctl.pred = PRED_ALL;
    finish   = 1'b0;
    inc      = 1'b0;
    dec      = 1'b0;
    unique case (state_q)
      S_FIND: ctl.mode = MODE_FIND;
      S_INSERT: begin
        if (out_free) begin
          finish = 1'b1;
          if (do_insert) begin
            ctl.mode = MODE_INSERT;
            inc      = !any_q;
          end
        end
      end
      S_POP: begin
        ctl.pred = PRED_POP;
        if (out_free) begin
          finish   = 1'b1;
          ctl.mode = MODE_REMOVE;
          dec      = rm_any;
        end
      end
      S_PRUNE: begin
        if (prune_cond) begin
          ctl.mode = MODE_REMOVE;
          dec      = 1'b1;
        end else begin
          finish = out_free;
        end
      end
      S_CLEAR: begin
        ctl.pred = PRED_CLEAR;
        if (rm_any) begin
          ctl.mode = MODE_REMOVE;
          dec      = 1'b1;
        end else begin
          finish = out_free;
        end
      end
      default: ;
    endcase
  end

  assign pending_nxt = pending_q + CNT_BITS'(inc) - CNT_BITS'(dec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pending_q   <= '0;
      min_q       <= PruneMinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_nxt;
      if (cfg_valid_i) begin
        min_q <= cfg_data_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(op_i);
      key_q      <= req_key_i;
      tv_q       <= time_value_i;
      rq_q       <= requester_i;
      ex_q       <= ExW'(exclude_mask_i);
      prune_en_q <= 32'(pending_q) > 32'(min_q);
    end
    if (state_q == S_FIND) begin
      any_q   <= m_any;
      mreq_q  <= m_req;
      lower_q <= tv_q < m_dl;
    end
    if (finish) begin
      found_q   <= (op_q == OP_POP) && rm_any;
      dropped_q <= (op_q == OP_ADD) && !any_q && full;
      okey_q    <= ((op_q == OP_POP) && rm_any) ? f_key : '0;
      odl_q     <= ((op_q == OP_POP) && rm_any) ? f_dl : '0;
      oreq_q    <= ((op_q == OP_POP) && rm_any) ? f_req : '0;
      occ_q     <= pending_nxt;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign dropped_o       = dropped_q;
  assign out_key_o       = okey_q;
  assign out_deadline_o  = odl_q;
  assign out_requester_o = oreq_q;
  assign occupancy_o     = occ_q;

endmodule

@@ hw/rtl/drq_checker.sv @@
module drq_checker #(
  parameter int unsigned DEPTH = drq_pkg::DepthDefault,
  parameter int unsigned KEY_BITS = drq_pkg::KeyBitsDefault,
  parameter int unsigned TIME_BITS = drq_pkg::TimeBitsDefault,
  parameter int unsigned REQ_BITS = 3,
  parameter int unsigned CNT_BITS = 6
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 found_o,
  input logic                 dropped_o,
  input logic [KEY_BITS-1:0]  out_key_o,
  input logic [TIME_BITS-1:0] out_deadline_o,
  input logic [REQ_BITS-1:0]  out_requester_o,
  input logic [CNT_BITS-1:0]  occupancy_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("queue took a second word without working on the first");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && dropped_o))
    else $error("found and dropped both set");

  a_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (out_key_o == '0) && (out_deadline_o == '0) &&
                                (out_requester_o == '0))
    else $error("entry payload set without a found entry");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(occupancy_o) <= DEPTH))
    else $error("occupancy beyond depth");

endmodule

bind deadline_request_queue_unit drq_checker #(
  .DEPTH    (DEPTH),
  .KEY_BITS (KEY_BITS),
  .TIME_BITS(TIME_BITS),
  .REQ_BITS (REQ_BITS),
  .CNT_BITS (CNT_BITS)
) u_drq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .dropped_o      (dropped_o),
  .out_key_o      (out_key_o),
  .out_deadline_o (out_deadline_o),
  .out_requester_o(out_requester_o),
  .occupancy_o    (occupancy_o)
);
